[hdl/pue_pkg.sv]
`timescale 1ns / 1ps

package pue_pkg;

    localparam int BYTE_W  = 8;
    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 17;
    localparam int SUM_W   = COUNT_W + 1;
    localparam int SLOT_W  = 2;

    localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [SIZE_W-1:0] SIZE_RESET   = 16'd256;

    localparam logic [SLOT_W-1:0] SLOT_FIRST = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_HIGH  = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_LOW   = 2'd2;

    localparam logic [BYTE_W-1:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              eos;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] ch0;
        logic [BYTE_W-1:0] ch1;
        logic [BYTE_W-1:0] ch2;
        logic [SLOT_W-1:0] final_slot;
        logic              status;
        logic              last;
    } group_t;

    function automatic logic passes_through(input logic [BYTE_W-1:0] c);
        logic hit;
        hit = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                         8'h21, 8'h23, 8'h24, 8'h27, 8'h28, 8'h29, 8'h2A,
                         8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h3A, 8'h40, 8'h5F,
                         8'h7E});
        return hit;
    endfunction

endpackage

[hdl/pue_in_stage.sv]
`timescale 1ns / 1ps

module pue_in_stage
    import pue_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              end_of_string,
    input  logic              take,
    output item_t             item
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              eos_reg;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_byte;
            eos_reg  <= end_of_string;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;
    assign item.eos   = eos_reg;

endmodule

[hdl/pue_encoder.sv]
`timescale 1ns / 1ps

module pue_encoder
    import pue_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data,
    input  item_t             item,
    input  logic              grp_free,
    output logic              take,
    output logic              load,
    output group_t            grp
);

    logic [SIZE_W-1:0]  buffer_size_reg;
    logic [COUNT_W-1:0] output_count_reg;
    logic [COUNT_W-1:0] output_count_next;
    logic               overflow_seen_reg;
    logic               overflow_seen_next;

    logic               pass;
    logic [SUM_W-1:0]   need;
    logic [SUM_W-1:0]   end_sum;
    logic [SUM_W-1:0]   byte_sum;
    logic [SUM_W-1:0]   size_ext;
    logic [SUM_W-1:0]   grown;
    logic               produces;

    assign cfg_ready = 1'b1;

    assign pass     = passes_through(item.data);
    assign need     = pass ? SUM_W'(1) : SUM_W'(3);
    assign size_ext = {{(SUM_W - SIZE_W){1'b0}}, buffer_size_reg};
    assign end_sum  = {1'b0, output_count_reg} + SUM_W'(1);
    assign grown    = {1'b0, output_count_reg} + need;
    assign byte_sum = grown + SUM_W'(1);

    always_comb
    begin
        produces           = 1'b0;
        output_count_next  = output_count_reg;
        overflow_seen_next = overflow_seen_reg;
        grp.ch0            = CHAR_NUL;
        grp.ch1            = HEX_DIGITS[item.data[7:4]];
        grp.ch2            = HEX_DIGITS[item.data[3:0]];
        grp.final_slot     = SLOT_FIRST;
        grp.status         = 1'b0;
        grp.last           = 1'b0;
        if (item.eos)
        begin
            produces           = 1'b1;
            grp.status         = overflow_seen_reg || (end_sum > size_ext);
            grp.last           = 1'b1;
            output_count_next  = '0;
            overflow_seen_next = 1'b0;
        end
        else if (!overflow_seen_reg)
        begin
            if (byte_sum > size_ext)
            begin
                overflow_seen_next = 1'b1;
            end
            else
            begin
                produces          = 1'b1;
                output_count_next = grown[COUNT_W-1:0];
                if (pass)
                begin
                    grp.ch0 = item.data;
                end
                else
                begin
                    grp.ch0        = CHAR_PERCENT;
                    grp.final_slot = SLOT_LOW;
                end
            end
        end
    end

    assign take = item.valid && (!produces || grp_free);
    assign load = take && produces;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg   <= SIZE_RESET;
            output_count_reg  <= '0;
            overflow_seen_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                buffer_size_reg <= cfg_data;
            end
            if (take)
            begin
                output_count_reg  <= output_count_next;
                overflow_seen_reg <= overflow_seen_next;
            end
        end
    end

endmodule

[hdl/pue_emitter.sv]
`timescale 1ns / 1ps

module pue_emitter
    import pue_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  group_t            grp,
    output logic              grp_free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              status,
    output logic              last
);

    group_t            grp_reg;
    logic              valid_reg;
    logic              valid_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              final_char;

    assign final_char = (slot_reg == grp_reg.final_slot);
    assign grp_free   = !valid_reg || (out_ready && final_char);

    always_comb
    begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        if (load)
        begin
            valid_next = 1'b1;
            slot_next  = SLOT_FIRST;
        end
        else if (valid_reg && out_ready)
        begin
            if (final_char)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                slot_next = slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            slot_reg  <= SLOT_FIRST;
        end
        else
        begin
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= grp;
        end
    end

    always_comb
    begin
        case (slot_reg)
            SLOT_FIRST: out_byte = grp_reg.ch0;
            SLOT_HIGH:  out_byte = grp_reg.ch1;
            SLOT_LOW:   out_byte = grp_reg.ch2;
            default:    out_byte = grp_reg.ch0;
        endcase
    end

    assign out_valid = valid_reg;
    assign status    = grp_reg.status;
    assign last      = grp_reg.last && final_char;

endmodule

[hdl/percent_url_encoder_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   in_byte[7:0], end_of_string
// out       output     out_valid / out_ready out_byte[7:0], status, last
// cfg       input      cfg_valid / cfg_ready cfg_data[15:0] (buffer size)
//
// An accepted request is registered by the input stage, then the output stage,
// before its first result. A pass-through byte or an end marker gives one
// character and an escaped byte three; the output stage gives one character per
// cycle while out_ready is high. Dropped bytes are consumed and give no result.
// Reset clears the pipeline, the count and the overflow flag, and sets the
// buffer size to 256. A stalled output holds its character until taken.

module percent_url_encoder_top
    import pue_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              end_of_string,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              status,
    output logic              last
);

    item_t  item;
    group_t grp;
    logic   take;
    logic   load;
    logic   grp_free;

    pue_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .take          (take),
        .item          (item)
    );

    pue_encoder u_encoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .item      (item),
        .grp_free  (grp_free),
        .take      (take),
        .load      (load),
        .grp       (grp)
    );

    pue_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .grp       (grp),
        .grp_free  (grp_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

endmodule
